>>> rtl/cleb_pkg.sv
// ----------------------------------------------------------------------------
// cleb_pkg
// Shared types and constants for the cursor line-edit buffer.
// ----------------------------------------------------------------------------
package cleb_pkg;

    localparam int BUFFER_DEPTH_DEF = 1024;

    localparam int FUNC_W    = 3;
    localparam int CH_W      = 8;
    localparam int INDEX_W   = 10;
    localparam int POS_W     = 11;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT    = 3'd0,
        FUNC_LEFT      = 3'd1,
        FUNC_RIGHT     = 3'd2,
        FUNC_BACKSPACE = 3'd3,
        FUNC_READ      = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load_cmd;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/cursor_line_edit_buffer_top.sv
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_top
// Line-edit buffer with a cursor, held as two character stacks.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                                   tuser
// s_axis    in   ch[7:0] index[17:8]                     func[2:0]
// m_axis    out  out_char[7:0] cursor_pos[18:8]          rejected[0]
//                text_length[29:19]
//
// Each command passes through accept, store read and commit, in that order.
// The store read step is there because the stack memories are read through a register.
// A new command is taken while the previous result waits on m_axis.
// A stalled result holds the commit; reset empties both stacks.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_top #(
    parameter int BUFFER_DEPTH = cleb_pkg::BUFFER_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cleb_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // ch, index, zero pad
    input  logic [cleb_pkg::FUNC_W-1:0]      s_axis_tuser,   // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [cleb_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // out_char, cursor_pos,
                                                             // text_length, zero pad
    output logic                             m_axis_tuser    // rejected
);

    cleb_pkg::ctrl_cmd_t  cmd;
    cleb_pkg::dp_status_t status;

    cleb_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    cleb_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/cleb_ctrl.sv
// ----------------------------------------------------------------------------
// cleb_ctrl
// Command sequencer: take a word, wait for the store read, then commit.
// ----------------------------------------------------------------------------
module cleb_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  cleb_pkg::dp_status_t   status,
    output cleb_pkg::ctrl_cmd_t    cmd
);

    cleb_pkg::state_t state_reg;
    cleb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cleb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd.load_cmd  = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            cleb_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load_cmd = 1'b1;
                    state_next   = cleb_pkg::ST_ISSUE;
                end
            end
            cleb_pkg::ST_ISSUE:
            begin
                state_next = cleb_pkg::ST_EXEC;
            end
            cleb_pkg::ST_EXEC:
            begin
                // hold until the output word is free
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = cleb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cleb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/cleb_datapath.sv
// ----------------------------------------------------------------------------
// cleb_datapath
// Left and right character stacks, their counts and the output register.
// ----------------------------------------------------------------------------
module cleb_datapath #(
    parameter int BUFFER_DEPTH = cleb_pkg::BUFFER_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cleb_pkg::ctrl_cmd_t              cmd,
    output cleb_pkg::dp_status_t             status,
    input  logic [cleb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [cleb_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [cleb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tuser
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int WW = ((CW > cleb_pkg::INDEX_W) ? CW : cleb_pkg::INDEX_W) + 1;
    localparam logic [WW-1:0] DEPTH_W = WW'(BUFFER_DEPTH);

    logic [cleb_pkg::CH_W-1:0] left_mem  [BUFFER_DEPTH];
    logic [cleb_pkg::CH_W-1:0] right_mem [BUFFER_DEPTH];

    logic [cleb_pkg::FUNC_W-1:0]  func_reg;
    logic [cleb_pkg::CH_W-1:0]    ch_reg;
    logic [cleb_pkg::INDEX_W-1:0] index_reg;

    logic [CW-1:0] lc_reg;
    logic [CW-1:0] lc_next;
    logic [CW-1:0] rc_reg;
    logic [CW-1:0] rc_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic [cleb_pkg::CH_W-1:0]  left_rdata_reg;
    logic [cleb_pkg::CH_W-1:0]  right_rdata_reg;
    logic [cleb_pkg::CH_W-1:0]  out_char_reg;
    logic [cleb_pkg::POS_W-1:0] cursor_pos_reg;
    logic [cleb_pkg::POS_W-1:0] text_length_reg;
    logic                       rejected_reg;

    logic [CW-1:0] total;
    logic [CW-1:0] total_next;
    logic [WW-1:0] idx_w;
    logic [WW-1:0] lc_w;
    logic [WW-1:0] rc_w;
    logic [WW-1:0] total_w;
    logic [WW-1:0] left_raddr_w;
    logic [WW-1:0] right_raddr_w;
    logic [AW-1:0] left_raddr;
    logic [AW-1:0] right_raddr;

    logic                      left_we;
    logic                      right_we;
    logic [cleb_pkg::CH_W-1:0] left_wdata;
    logic [cleb_pkg::CH_W-1:0] res_char;
    logic                      res_rej;

    assign total   = CW'(lc_reg + rc_reg);
    assign idx_w   = WW'(index_reg);
    assign lc_w    = WW'(lc_reg);
    assign rc_w    = WW'(rc_reg);
    assign total_w = WW'(total);

    assign left_raddr_w  = (func_reg == cleb_pkg::FUNC_LEFT)  ? (lc_w - WW'(1)) : idx_w;
    assign right_raddr_w = (func_reg == cleb_pkg::FUNC_RIGHT) ? (rc_w - WW'(1))
                                                              : (total_w - WW'(1) - idx_w);
    assign left_raddr    = left_raddr_w[AW-1:0];
    assign right_raddr   = right_raddr_w[AW-1:0];

    always_comb
    begin
        lc_next    = lc_reg;
        rc_next    = rc_reg;
        left_we    = 1'b0;
        right_we   = 1'b0;
        left_wdata = ch_reg;
        res_char   = '0;
        res_rej    = 1'b0;
        unique case (func_reg)
            cleb_pkg::FUNC_INSERT:
            begin
                if (total_w >= DEPTH_W)
                begin
                    res_rej = 1'b1;
                end
                else
                begin
                    left_we = 1'b1;
                    lc_next = lc_reg + CW'(1);
                end
            end
            cleb_pkg::FUNC_LEFT:
            begin
                if (lc_reg != '0)
                begin
                    right_we = 1'b1;
                    lc_next  = lc_reg - CW'(1);
                    rc_next  = rc_reg + CW'(1);
                end
            end
            cleb_pkg::FUNC_RIGHT:
            begin
                if (rc_reg != '0)
                begin
                    left_we    = 1'b1;
                    left_wdata = right_rdata_reg;
                    rc_next    = rc_reg - CW'(1);
                    lc_next    = lc_reg + CW'(1);
                end
            end
            cleb_pkg::FUNC_BACKSPACE:
            begin
                if (lc_reg != '0)
                begin
                    lc_next = lc_reg - CW'(1);
                end
            end
            cleb_pkg::FUNC_READ:
            begin
                if (idx_w >= total_w)
                begin
                    res_rej = 1'b1;
                end
                else if (idx_w < lc_w)
                begin
                    res_char = left_rdata_reg;
                end
                else
                begin
                    res_char = right_rdata_reg;
                end
            end
            default:
            begin
                res_rej = 1'b0;
            end
        endcase
    end

    assign total_next = CW'(lc_next + rc_next);

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign status.out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg        <= '0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.commit)
            begin
                lc_reg <= lc_next;
                rc_reg <= rc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cmd)
        begin
            func_reg  <= s_axis_tuser;
            ch_reg    <= s_axis_tdata[cleb_pkg::CH_W-1:0];
            index_reg <= s_axis_tdata[cleb_pkg::CH_W +: cleb_pkg::INDEX_W];
        end
        if (cmd.commit)
        begin
            out_char_reg    <= res_char;
            cursor_pos_reg  <= cleb_pkg::POS_W'(lc_next);
            text_length_reg <= cleb_pkg::POS_W'(total_next);
            rejected_reg    <= res_rej;
        end
    end

    always_ff @(posedge clk)
    begin
        left_rdata_reg  <= left_mem[left_raddr];
        right_rdata_reg <= right_mem[right_raddr];
        if (cmd.commit && left_we)
        begin
            left_mem[lc_reg[AW-1:0]] <= left_wdata;
        end
        if (cmd.commit && right_we)
        begin
            right_mem[rc_reg[AW-1:0]] <= left_rdata_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = rejected_reg;
    assign m_axis_tdata  = {2'b00, text_length_reg, cursor_pos_reg, out_char_reg};

endmodule
